/* design/csv_field_splitter_core_macros.svh */
// ----------------------------------------------------------------------------
// CSV field splitter assertion macros
// Shared concurrent assertion forms used by the splitter top level.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

// An implication or plain property, checked on every rising edge outside reset.
`define CSF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true outside reset.
`define CSF_ASSERT_NEVER(label, clk, rst, cond, msg) \
  `CSF_ASSERT(label, clk, rst, !(cond), msg)

// A property checked on every rising edge, reset included.
`define CSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/csf_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field splitter package
// Character codes, output field widths and the byte class record.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int IDX_W   = 5;
  localparam int OFS_W   = 10;
  localparam int LEN_MAX = 1023;

  // Class of one line byte, as the tokenizer needs it.
  typedef struct packed {
    logic is_space;
    logic is_comma;
    logic is_quote;
    logic is_lf;
  } byte_cls_t;

  localparam int CLS_W = $bits(byte_cls_t);

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    c.is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    c.is_comma = (b == CH_COMMA);
    c.is_quote = (b == CH_QUOTE);
    c.is_lf    = (b == CH_LF);
    return c;
  endfunction

endpackage

/* design/csf_front.sv */
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Accepts line bytes, classifies them and tags each with its line offset.
// ----------------------------------------------------------------------------
module csf_front #(
  parameter int MAX_LINE = 1024,
  parameter int PW       = $clog2(MAX_LINE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         byte_in,
  input  logic               end_of_line,
  output csf_pkg::byte_cls_t cls,
  output logic [PW-1:0]      pos,
  output logic               eol
);
  import csf_pkg::*;

  logic [PW-1:0] line_position;

  assign cls = classify(byte_in);
  assign pos = line_position;
  assign eol = end_of_line;

  // Offsets stop at the last legal value on an overlong line.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
    end else if (take) begin
      if (end_of_line) begin
        line_position <= '0;
      end else if (line_position < PW'(MAX_LINE - 1)) begin
        line_position <= line_position + 1'b1;
      end
    end
  end

endmodule

/* design/csf_queue.sv */
// ----------------------------------------------------------------------------
// CSV field splitter queue
// Two-entry queue that decouples the front end from the tokenizer.
// ----------------------------------------------------------------------------
module csf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         nonempty,
  output logic [W-1:0] head
);
  import csf_pkg::*;

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/csf_back.sv */
// ----------------------------------------------------------------------------
// CSV field splitter tokenizer
// Runs the field state per classified byte and holds the result register.
// ----------------------------------------------------------------------------
module csf_back #(
  parameter int MAX_FIELDS = 20,
  parameter int MAX_LINE   = 1024,
  parameter int PW         = $clog2(MAX_LINE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_nonempty,
  input  csf_pkg::byte_cls_t          q_cls,
  input  logic [PW-1:0]               q_pos,
  input  logic                        q_eol,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csf_pkg::IDX_W-1:0]   field_index,
  output logic [csf_pkg::OFS_W-1:0]   field_start,
  output logic [csf_pkg::OFS_W-1:0]   field_length,
  output logic                        was_quoted,
  output logic                        last_field
);
  import csf_pkg::*;

  localparam int CW = $clog2(MAX_FIELDS + 1);

  // Field state.
  logic [CW-1:0] field_count, field_count_next;
  logic          at_field_start, at_field_start_next;
  logic          in_quoted_field, in_quoted_field_next;
  logic          quote_pending, quote_pending_next;
  logic [PW-1:0] quote_offset, quote_offset_next;
  logic [PW-1:0] first_nonspace, first_nonspace_next;
  logic [PW-1:0] last_nonspace, last_nonspace_next;
  logic          seen_nonspace, seen_nonspace_next;
  logic          line_done, line_done_next;

  logic          emit;
  logic          handled;
  logic          is_last;
  logic          quoted;
  logic [PW:0]   span;
  logic [OFS_W-1:0] start_val;
  logic [OFS_W-1:0] len_val;

  assign pop = q_nonempty && (!out_valid || !out_stall);

  always_comb begin
    field_count_next     = field_count;
    at_field_start_next  = at_field_start;
    in_quoted_field_next = in_quoted_field;
    quote_pending_next   = quote_pending;
    quote_offset_next    = quote_offset;
    first_nonspace_next  = first_nonspace;
    last_nonspace_next   = last_nonspace;
    seen_nonspace_next   = seen_nonspace;
    line_done_next       = line_done;
    emit                 = 1'b0;
    handled              = 1'b0;

    if (!line_done) begin
      if (at_field_start && q_cls.is_quote) begin
        at_field_start_next  = 1'b0;
        in_quoted_field_next = 1'b1;
        quote_pending_next   = 1'b0;
        emit                 = q_eol;
      end else if (at_field_start || !in_quoted_field) begin
        at_field_start_next = 1'b0;
        if (q_cls.is_comma) begin
          emit = 1'b1;
        end else begin
          if (!q_cls.is_space) begin
            if (!seen_nonspace_next) begin
              first_nonspace_next = q_pos;
            end
            last_nonspace_next = q_pos;
            seen_nonspace_next = 1'b1;
          end
          emit = q_eol;
        end
      end else begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (q_cls.is_comma || q_cls.is_lf) begin
            emit    = 1'b1;
            handled = 1'b1;
          end else begin
            // The pending quote turns out to be content.
            if (!seen_nonspace_next) begin
              first_nonspace_next = quote_offset;
            end
            last_nonspace_next = quote_offset;
            seen_nonspace_next = 1'b1;
          end
        end
        if (!handled) begin
          if (q_cls.is_quote) begin
            if (q_eol) begin
              emit = 1'b1;
            end else begin
              quote_pending_next = 1'b1;
              quote_offset_next  = q_pos;
            end
          end else begin
            if (!q_cls.is_space) begin
              if (!seen_nonspace_next) begin
                first_nonspace_next = q_pos;
              end
              last_nonspace_next = q_pos;
              seen_nonspace_next = 1'b1;
            end
            emit = q_eol;
          end
        end
      end
    end

    is_last = q_eol || (field_count >= CW'(MAX_FIELDS - 1));
    quoted  = in_quoted_field_next;

    span      = {1'b0, last_nonspace_next} - {1'b0, first_nonspace_next} + 1'b1;
    start_val = '0;
    len_val   = '0;
    if (seen_nonspace_next && (last_nonspace_next >= first_nonspace_next)) begin
      start_val = OFS_W'(first_nonspace_next);
      if (32'(span) > 32'(LEN_MAX)) begin
        len_val = OFS_W'(LEN_MAX);
      end else begin
        len_val = OFS_W'(span);
      end
    end

    if (emit) begin
      field_count_next     = field_count + 1'b1;
      at_field_start_next  = 1'b1;
      in_quoted_field_next = 1'b0;
      quote_pending_next   = 1'b0;
      seen_nonspace_next   = 1'b0;
      first_nonspace_next  = '0;
      last_nonspace_next   = '0;
      if (is_last && !q_eol) begin
        line_done_next = 1'b1;
      end
    end

    // The line end clears all line state, skipped lines included.
    if (q_eol) begin
      field_count_next     = '0;
      at_field_start_next  = 1'b1;
      in_quoted_field_next = 1'b0;
      quote_pending_next   = 1'b0;
      quote_offset_next    = '0;
      first_nonspace_next  = '0;
      last_nonspace_next   = '0;
      seen_nonspace_next   = 1'b0;
      line_done_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count     <= '0;
      at_field_start  <= 1'b1;
      in_quoted_field <= 1'b0;
      quote_pending   <= 1'b0;
      quote_offset    <= '0;
      first_nonspace  <= '0;
      last_nonspace   <= '0;
      seen_nonspace   <= 1'b0;
      line_done       <= 1'b0;
    end else if (pop) begin
      field_count     <= field_count_next;
      at_field_start  <= at_field_start_next;
      in_quoted_field <= in_quoted_field_next;
      quote_pending   <= quote_pending_next;
      quote_offset    <= quote_offset_next;
      first_nonspace  <= first_nonspace_next;
      last_nonspace   <= last_nonspace_next;
      seen_nonspace   <= seen_nonspace_next;
      line_done       <= line_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      field_index  <= IDX_W'(field_count);
      field_start  <= start_val;
      field_length <= len_val;
      was_quoted   <= quoted;
      last_field   <= is_last;
    end
  end

endmodule

/* design/csv_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// CSV field splitter core
// Splits a byte stream of text lines into comma separated field descriptors.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, byte_in, end_of_line) takes
// one line byte per beat, with end_of_line high on the last byte of a line.
// The output channel (out_valid, out_stall and the field ports) gives one
// beat per completed field: its index, trimmed start offset and length,
// whether it opened with a double quote, and whether it is the last field
// that the line reports. Only the first MAX_FIELDS fields of a line appear.
// An accepted byte is written into the two-entry queue, and the field beat
// it closes is registered in the output register. Throughput is one byte
// per cycle while out_stall is low, set by the tokenizer step at the queue head.
// While the receiver stalls, the held result waits in the output register,
// the queue fills with up to two bytes and then in_stall rises.
// Reset (rst, synchronous) empties the queue and output register and starts
// a fresh line at offset zero; in_stall is low in the first cycle after it.
// ----------------------------------------------------------------------------
module csv_field_splitter_core #(
  parameter int MAX_FIELDS = 20,
  parameter int MAX_LINE   = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                byte_in,
  input  logic                      end_of_line,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [csf_pkg::IDX_W-1:0] field_index,
  output logic [csf_pkg::OFS_W-1:0] field_start,
  output logic [csf_pkg::OFS_W-1:0] field_length,
  output logic                      was_quoted,
  output logic                      last_field
);
  import csf_pkg::*;

  `include "csv_field_splitter_core_macros.svh"

  localparam int PW = $clog2(MAX_LINE);
  localparam int QW = CLS_W + PW + 1;

  // Front end to queue.
  logic          take;
  byte_cls_t     f_cls;
  logic [PW-1:0] f_pos;
  logic          f_eol;

  // Queue to tokenizer.
  logic          q_full;
  logic          q_nonempty;
  logic [QW-1:0] q_head;
  byte_cls_t     q_cls;
  logic [PW-1:0] q_pos;
  logic          q_eol;
  logic          pop;

  // A byte is taken whenever the queue has room.
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  csf_front #(
    .MAX_LINE (MAX_LINE),
    .PW       (PW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .byte_in     (byte_in),
    .end_of_line (end_of_line),
    .cls         (f_cls),
    .pos         (f_pos),
    .eol         (f_eol)
  );

  csf_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data ({f_cls, f_pos, f_eol}),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  assign {q_cls, q_pos, q_eol} = q_head;

  // The tokenizer steps once per queued byte while the output register
  // is free or being drained in the same cycle.
  csf_back #(
    .MAX_FIELDS (MAX_FIELDS),
    .MAX_LINE   (MAX_LINE),
    .PW         (PW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_cls        (q_cls),
    .q_pos        (q_pos),
    .q_eol        (q_eol),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_index  (field_index),
    .field_start  (field_start),
    .field_length (field_length),
    .was_quoted   (was_quoted),
    .last_field   (last_field)
  );

  // Checks across the queue, the tokenizer and the output register.
  `CSF_ASSERT(a_pop_needs_data, clk, rst, pop |-> q_nonempty, "pop from an empty queue")
  `CSF_ASSERT_NEVER(a_no_step_when_held, clk, rst, out_valid && out_stall && pop, "tokenizer stepped over a held result")
  `CSF_ASSERT(a_index_in_range, clk, rst, out_valid |-> (32'(field_index) < 32'(MAX_FIELDS)), "field index beyond limit")
  `CSF_ASSERT_ALWAYS(a_ready_after_reset, clk, rst |=> !in_stall, "input stalled right after reset")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter core testbench
// Feeds text lines one byte per beat and checks every field descriptor against
// an in-bench tokenizer or a hand-written row, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import csf_pkg::*;

  localparam int FIELD_LIMIT    = 20;
  localparam int LINE_LIMIT     = 1024;
  localparam int RANDOM_BEATS   = 150;
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int OVERLONG_BYTES = 1040;

  // One field descriptor, laid out in port order.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] len;
    logic             quoted;
    logic             is_last;
  } field_desc_t;

  // A byte beat may carry a hand-written expectation; otherwise the
  // tokenizer below decides what the beat produces.
  typedef struct packed {
    logic        pinned;
    field_desc_t want;
  } pin_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eol;
    logic        pinned;
    field_desc_t want;
  } plan_row_t;

  // Tokenizer state for the line in progress.
  typedef struct {
    logic [OFS_W-1:0] pos;
    int               count;
    bit               at_start;
    bit               in_quotes;
    bit               quote_open;
    logic [OFS_W-1:0] quote_pos;
    logic [OFS_W-1:0] first_kept;
    logic [OFS_W-1:0] last_kept;
    bit               seen_kept;
    bit               skip_rest;
  } line_scan_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       byte_in = 8'h00;
  logic             end_of_line = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] field_index;
  logic [OFS_W-1:0] field_start;
  logic [OFS_W-1:0] field_length;
  logic             was_quoted;
  logic             last_field;

  line_scan_t  scan;
  field_desc_t field_q[$];
  pin_t        pinned_q[$];
  logic [7:0]  line_buf[$];

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_asked = 0;
  int hold_given = 0;
  int rx_wait = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_bytes = 0;
  int n_lines = 0;
  int n_fields = 0;
  int n_capped = 0;
  int n_ceiling = 0;

  always #5 clk = ~clk;

  csv_field_splitter_core #(
    .MAX_FIELDS (FIELD_LIMIT),
    .MAX_LINE   (LINE_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_index  (field_index),
    .field_start  (field_start),
    .field_length (field_length),
    .was_quoted   (was_quoted),
    .last_field   (last_field)
  );

  // --------------------------------------------------------------------------
  // Tokenizer used for prediction.
  // --------------------------------------------------------------------------

  // Clears everything that belongs to one line; used at reset and after the
  // byte that ends a line.
  task automatic start_line();
    scan.pos        = '0;
    scan.count      = 0;
    scan.at_start   = 1'b1;
    scan.in_quotes  = 1'b0;
    scan.quote_open = 1'b0;
    scan.quote_pos  = '0;
    scan.first_kept = '0;
    scan.last_kept  = '0;
    scan.seen_kept  = 1'b0;
    scan.skip_rest  = 1'b0;
  endtask

  // Whitespace is the space and the control codes from tab to carriage return.
  function automatic bit is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Widens the kept-content window to a non-blank byte at offset p.
  task automatic note_kept(input logic [7:0] b, input logic [OFS_W-1:0] p);
    if (!is_blank(b)) begin
      if (!scan.seen_kept) scan.first_kept = p;
      scan.last_kept = p;
      scan.seen_kept = 1'b1;
    end
  endtask

  // Produces the descriptor of the open field and readies the next one.
  task automatic close_field(input bit eol, output field_desc_t f);
    bit ends_line;
    int span;
    ends_line = eol || (scan.count + 1 >= FIELD_LIMIT);
    f = '0;
    f.idx = IDX_W'(scan.count);
    if (scan.seen_kept && scan.last_kept >= scan.first_kept) begin
      span  = int'(scan.last_kept) - int'(scan.first_kept) + 1;
      f.ofs = scan.first_kept;
      f.len = (span > LEN_MAX) ? OFS_W'(LEN_MAX) : OFS_W'(span);
    end
    f.quoted  = scan.in_quotes;
    f.is_last = ends_line;
    scan.count++;
    scan.at_start   = 1'b1;
    scan.in_quotes  = 1'b0;
    scan.quote_open = 1'b0;
    scan.seen_kept  = 1'b0;
    scan.first_kept = '0;
    scan.last_kept  = '0;
    if (ends_line && !eol) scan.skip_rest = 1'b1;
  endtask

  // Advances the tokenizer by one line byte; made is set when the byte
  // completes a field, and f then holds its descriptor.
  task automatic tokenize_byte(input logic [7:0] b, input bit eol,
                               output bit made, output field_desc_t f);
    bit consumed;
    made = 1'b0;
    f    = '0;
    if (scan.skip_rest) begin
      // Past the field limit: the rest of the line is dropped.
    end else if (scan.at_start && b == CH_QUOTE) begin
      scan.at_start   = 1'b0;
      scan.in_quotes  = 1'b1;
      scan.quote_open = 1'b0;
      scan.seen_kept  = 1'b0;
      if (eol) begin
        close_field(1'b1, f);
        made = 1'b1;
      end
    end else if (scan.at_start || !scan.in_quotes) begin
      scan.at_start = 1'b0;
      if (b == CH_COMMA) begin
        close_field(eol, f);
        made = 1'b1;
      end else begin
        note_kept(b, scan.pos);
        if (eol) begin
          close_field(1'b1, f);
          made = 1'b1;
        end
      end
    end else begin
      consumed = 1'b0;
      // A quote seen on the previous byte closes the field only when a
      // comma or a line feed follows; otherwise it is ordinary content.
      if (scan.quote_open) begin
        scan.quote_open = 1'b0;
        if (b == CH_COMMA || b == CH_LF) begin
          close_field(eol, f);
          made     = 1'b1;
          consumed = 1'b1;
        end else begin
          note_kept(CH_QUOTE, scan.quote_pos);
        end
      end
      if (!consumed) begin
        if (b == CH_QUOTE) begin
          if (eol) begin
            close_field(1'b1, f);
            made = 1'b1;
          end else begin
            scan.quote_open = 1'b1;
            scan.quote_pos  = scan.pos;
          end
        end else begin
          note_kept(b, scan.pos);
          if (eol) begin
            close_field(1'b1, f);
            made = 1'b1;
          end
        end
      end
    end
    // Offsets stick at the last one once a line runs past its maximum length.
    if (eol) start_line();
    else if (scan.pos < OFS_W'(LINE_LIMIT - 1)) scan.pos = scan.pos + 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Monitor and scoreboard. Both channels are sampled at the rising edge, so
  // every value read here is the one from before the edge.
  // --------------------------------------------------------------------------

  task automatic check_part(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    field_desc_t pred;
    field_desc_t want;
    field_desc_t got;
    pin_t        pin;
    bit          made;
    bit          moved;
    if (rst) begin
      start_line();
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pin = pinned_q.pop_front();
        tokenize_byte(byte_in, end_of_line, made, pred);
        if (made) begin
          // Hand-written rows of the directed table override the tokenizer.
          field_q.push_back(pin.pinned ? pin.want : pred);
          if (pred.is_last && !end_of_line) n_capped++;
          if (pred.len == OFS_W'(LEN_MAX)) n_ceiling++;
        end
        n_bytes++;
        if (end_of_line) n_lines++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = {field_index, field_start, field_length, was_quoted, last_field};
        if (field_q.size() == 0) begin
          errors++;
          $display("%0t ns: field beat with nothing expected, expected none, got %h",
                   $time, got);
        end else begin
          want = field_q.pop_front();
          check_part("field_index", want.idx, got.idx);
          check_part("field_start", want.ofs, got.ofs);
          check_part("field_length", want.len, got.len);
          check_part("was_quoted", want.quoted, got.quoted);
          check_part("last_field", want.is_last, got.is_last);
        end
        n_fields++;
      end
      // Watchdog: a long run of edges with no beat on either side is a hang.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d fields still due",
                 $time, WATCHDOG_LIMIT, field_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls for a random count of cycles before each field beat.
  // A hold request from the stimulus makes it hold off for a long stretch so
  // the core fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit took;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      took = out_valid && !out_stall;
      if (hold_asked != hold_given) begin
        hold_given++;
        rx_wait = LONG_HOLD;
      end else if (took) begin
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Offers one byte beat after a random gap and returns at the edge that
  // accepts it. With no gap, valid simply stays high into the next beat.
  task automatic send_beat(input logic [7:0] b, input bit eol, input bit pinned,
                           input field_desc_t want);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    pinned_q.push_back({pinned, want});
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_in     <= b;
    end_of_line <= eol;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every outstanding field beat has arrived.
  task automatic wait_for_fields();
    in_valid <= 1'b0;
    do @(posedge clk); while (field_q.size() != 0 || pinned_q.size() != 0);
  endtask

  // One byte of field content. Commas and quotes only appear inside quoted
  // fields, where they are content (a quote may still close the field early).
  function automatic logic [7:0] text_byte(input bit in_quotes);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(0, 25));
      4: c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
      5: c = in_quotes ? CH_COMMA : 8'h30 + 8'($urandom_range(0, 9));
      6: c = in_quotes ? CH_QUOTE : 8'h41 + 8'($urandom_range(0, 25));
      default: begin
        c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || (!in_quotes && c == CH_QUOTE))
          c = 8'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  // Directed lines. Rows with the pinned bit carry an expectation that can
  // be read straight off the line; the rest go through the tokenizer.
  plan_row_t plan [24] = '{
    // A lone comma that also ends the line: one empty last field.
    {CH_COMMA, 1'b1, 1'b1, 5'd0, 10'd0, 10'd0, 1'b0, 1'b1},
    // A quote that opens a field as the final byte: empty quoted field.
    {CH_QUOTE, 1'b1, 1'b1, 5'd0, 10'd0, 10'd0, 1'b1, 1'b1},
    // Two commas: two empty fields, the second closed by the comma that ends the line.
    {CH_COMMA, 1'b0, 1'b1, 5'd0, 10'd0, 10'd0, 1'b0, 1'b0},
    {CH_COMMA, 1'b1, 1'b1, 5'd1, 10'd0, 10'd0, 1'b0, 1'b1},
    // Top byte value as a one-byte line.
    {8'hFF,    1'b1, 1'b1, 5'd0, 10'd0, 10'd1, 1'b0, 1'b1},
    // Whitespace trimmed on both sides of a single letter.
    {CH_SPACE, 1'b0, 1'b0, 27'd0},
    {8'h61,    1'b0, 1'b0, 27'd0},
    {CH_TAB,   1'b0, 1'b0, 27'd0},
    {CH_CR,    1'b1, 1'b1, 5'd0, 10'd1, 10'd1, 1'b0, 1'b1},
    // Quoted field with a quote inside that turns into content, closed by
    // a quote and comma, then the byte value 8'h01 as the last field.
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {8'h61,    1'b0, 1'b0, 27'd0},
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {8'h62,    1'b0, 1'b0, 27'd0},
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {CH_COMMA, 1'b0, 1'b0, 27'd0},
    {8'h01,    1'b1, 1'b0, 27'd0},
    // Quoted field never closed: runs to the line end.
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {8'h7A,    1'b1, 1'b0, 27'd0},
    // Quoted field closed by a quote and a line feed before the line ends.
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {8'h71,    1'b0, 1'b0, 27'd0},
    {CH_QUOTE, 1'b0, 1'b0, 27'd0},
    {CH_LF,    1'b0, 1'b0, 27'd0},
    {8'h72,    1'b1, 1'b0, 27'd0}
  };

  initial begin
    int rand_beats;
    int nf;
    int n;
    int kind;
    bit quiet;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table first.
    foreach (plan[i]) send_beat(plan[i].b, plan[i].eol, plan[i].pinned, plan[i].want);
    // The sender pauses here until every field of the table is back.
    wait_for_fields();

    // Back pressure: the receiver holds off for a long stretch while a
    // comma-rich line streams in without gaps, so the core must stall.
    line_buf.delete();
    for (int k = 0; k < 6; k++) begin
      if (k > 0) line_buf.push_back(CH_COMMA);
      line_buf.push_back(8'h61 + 8'(k));
    end
    hold_asked++;
    tx_quiet = 1'b1;
    foreach (line_buf[i]) send_beat(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
    tx_quiet = 1'b0;
    wait_for_fields();

    // Random lines: mostly well-formed records with random content, some
    // past the field limit, and some plain noise.
    rand_beats = 0;
    while (rand_beats < RANDOM_BEATS) begin
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: line_buf.push_back(CH_COMMA);
            1: line_buf.push_back(CH_QUOTE);
            2: line_buf.push_back(8'($urandom_range(9, 13)));
            default: line_buf.push_back(8'($urandom_range(1, 255)));
          endcase
        end
      end else begin
        nf = (kind < 18) ? $urandom_range(19, 24) : $urandom_range(1, 6);
        for (int k = 0; k < nf; k++) begin
          if (k > 0) line_buf.push_back(CH_COMMA);
          case ($urandom_range(0, 9))
            0, 1: ;  // empty field
            2, 3, 4: begin
              line_buf.push_back(CH_QUOTE);
              n = $urandom_range(0, 6);
              repeat (n) line_buf.push_back(text_byte(1'b1));
              // Mostly closed; sometimes left open or followed by junk.
              if ($urandom_range(0, 7) != 0) line_buf.push_back(CH_QUOTE);
              if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_SPACE);
            end
            default: begin
              n = $urandom_range(1, 8);
              repeat (n) line_buf.push_back(text_byte(1'b0));
            end
          endcase
        end
        if ($urandom_range(0, 4) == 0) line_buf.push_back(CH_COMMA);
        if (line_buf.size() == 0) line_buf.push_back(8'h78);
      end
      // Some lines run with no idling on either side.
      quiet = ($urandom_range(0, 5) == 0);
      tx_quiet = quiet;
      rx_quiet = quiet;
      foreach (line_buf[i]) begin
        send_beat(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
        rand_beats++;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_for_fields();

    // Overlong line: offsets stick at the top and the length hits its ceiling.
    line_buf.delete();
    for (int k = 0; k < OVERLONG_BYTES; k++)
      line_buf.push_back((k % 97 == 50) ? CH_SPACE : 8'h61 + 8'($urandom_range(0, 25)));
    foreach (line_buf[i]) send_beat(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
    wait_for_fields();
    repeat (8) @(posedge clk);

    $display("Covered %0d line bytes in %0d lines and checked %0d field beats.",
             n_bytes, n_lines, n_fields);
    $display("%0d lines were cut at the field limit, %0d fields hit the length ceiling.",
             n_capped, n_ceiling);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
